@@ rtl/core/soas_pkg.sv @@
// Shared types and constants for the sensor outlier average and slope unit.
package soas_pkg;

   // Field widths
   localparam int TEMP_W     = 12;
   localparam int TIME_W     = 32;
   localparam int SLOPE_W    = 21;
   localparam int STATUS_W   = 2;
   localparam int MASK_W     = 8;
   localparam int CSR_W      = 4;

   // Default maximum number of sensors per round
   localparam int MAX_SENSORS_DEFAULT = 8;

   // Slope arithmetic
   localparam int MS_PER_S    = 1000;
   localparam int SLOPE_LIMIT = 1000000;
   localparam int DT_W        = TEMP_W + 1;   // difference of two averages
   localparam int PROD_W      = DT_W + 10;    // difference times 1000

   // Serial divider: dividend holds the magnitude of the scaled difference
   localparam int DIV_W      = PROD_W - 1;
   localparam int DIVISOR_W  = TIME_W;
   localparam int DIV_STEP_W = $clog2(DIV_W + 1);

   // Round status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_ALL_GOOD      = 2'd0,
      STATUS_SOME_REJECTED = 2'd1,
      STATUS_ALL_REJECTED  = 2'd2
   } soas_status_type;

   // One result as it sits in the result queue
   typedef struct packed {
      logic signed [TEMP_W-1:0]  average_temp;
      logic signed [SLOPE_W-1:0] temp_slope;
      logic [STATUS_W-1:0]       status;
      logic [MASK_W-1:0]         rejected_mask;
   } soas_result_type;

   // Reference info handed from the back end to the front end
   typedef struct packed {
      logic                     primed;
      logic signed [TEMP_W-1:0] ref_avg;
   } soas_hint_type;

   // Divider command
   typedef struct packed {
      logic                   start;
      logic [DIV_W-1:0]       dividend;
      logic [DIVISOR_W-1:0]   divisor;
      logic [DIV_STEP_W-1:0]  steps;
   } soas_div_req_type;

   // Divider answer
   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } soas_div_rsp_type;

endpackage

@@ rtl/core/sensor_outlier_average_and_slope_unit.sv @@
// Top level of the sensor outlier average and slope unit.
// Samples enter on the request queue (req_push / req_full), one per sensor,
//   csr_sensor_count per round (0 acts as 1, above MAX_SENSORS acts as
//   MAX_SENSORS); the last sample's timestamp is the round time. Each round
//   yields one result on the response queue (rsp_empty / rsp_pop): latest
//   average, slope in 1/16 degree per second, status and reject mask.
// csr_valid / csr_ready writes the round length; csr_ready is always high.
// Timing: samples within a round are taken one per cycle. After a round's
//   last sample is accepted, a shared serial divider forms the average, then
//   the slope, one quotient bit per cycle, and the result then enters the
//   response queue. The first sample of the next round waits (req_full high)
//   until the back end is idle again, since its outlier reference comes from
//   the updated history.
// Reset: synchronous; clears both queues, the history and the primed flag,
//   and sets the round length to 1.
// Back pressure: two results are buffered; when the response queue is full
//   the back end holds its finished result and the front end then stops
//   taking samples.
module sensor_outlier_average_and_slope_unit #(
   parameter int MAX_SENSORS = soas_pkg::MAX_SENSORS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Sample requests
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [soas_pkg::TEMP_W-1:0]  req_temperature,
   input  logic [soas_pkg::TIME_W-1:0]         req_time_ms,
   // Results
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [soas_pkg::TEMP_W-1:0]  rsp_average_temp,
   output logic signed [soas_pkg::SLOPE_W-1:0] rsp_temp_slope,
   output logic [soas_pkg::STATUS_W-1:0]       rsp_status,
   output logic [soas_pkg::MASK_W-1:0]         rsp_rejected_mask,
   // Round length register
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [soas_pkg::CSR_W-1:0]          csr_sensor_count
);
   import soas_pkg::*;

   localparam int CNT_W   = $clog2(MAX_SENSORS + 1);
   localparam int SUM_W   = TEMP_W + CNT_W;
   localparam int REC_W   = SUM_W + CNT_W + MAX_SENSORS + TIME_W;
   localparam int RES_W   = $bits(soas_result_type);
   localparam int Q_DEPTH = 2;

   logic [CSR_W-1:0] sensor_count_ff;
   logic             rec_push, rec_pop, rec_full, rec_empty;
   logic [REC_W-1:0] rec_wr, rec_rd;
   logic             res_push, res_full;
   soas_result_type  res_wr, res_rd;
   logic [RES_W-1:0] res_rd_bits;
   soas_hint_type    hint;
   logic             back_idle;
   logic             back_quiet;
   soas_div_req_type div_req;
   soas_div_rsp_type div_rsp;

   // Round length register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_count_ff <= CSR_W'(1);
      end else if (csr_valid && csr_ready) begin
         sensor_count_ff <= csr_sensor_count;
      end
   end

   assign back_quiet = back_idle && rec_empty;

   soas_front #(
      .MAX_SENSORS (MAX_SENSORS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_temperature (req_temperature),
      .req_time_ms     (req_time_ms),
      .sensor_count    (sensor_count_ff),
      .back_quiet      (back_quiet),
      .hint            (hint),
      .rec_push        (rec_push),
      .rec_data        (rec_wr)
   );

   // Round records between front and back
   soas_fifo #(
      .WIDTH (REC_W),
      .DEPTH (Q_DEPTH)
   ) u_rec_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rec_push),
      .wr_data (rec_wr),
      .full    (rec_full),
      .pop     (rec_pop),
      .rd_data (rec_rd),
      .empty   (rec_empty)
   );

   soas_back #(
      .MAX_SENSORS (MAX_SENSORS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_empty (rec_empty),
      .rec_pop   (rec_pop),
      .rec_data  (rec_rd),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_wr),
      .hint      (hint),
      .idle      (back_idle),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   soas_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Result queue
   soas_fifo #(
      .WIDTH (RES_W),
      .DEPTH (Q_DEPTH)
   ) u_res_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_wr),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_rd_bits),
      .empty   (rsp_empty)
   );

   assign res_rd            = soas_result_type'(res_rd_bits);
   assign rsp_average_temp  = res_rd.average_temp;
   assign rsp_temp_slope    = res_rd.temp_slope;
   assign rsp_status        = res_rd.status;
   assign rsp_rejected_mask = res_rd.rejected_mask;

   // The record queue never fills: a round starts only when it is empty
   logic unused_rec_full;
   assign unused_rec_full = rec_full;

endmodule

@@ rtl/core/soas_fifo.sv @@
// Small synchronous queue built from registers.
module soas_fifo #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 2,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

@@ rtl/core/soas_divider.sv @@
// Restoring serial divider, one quotient bit per cycle.
module soas_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  soas_pkg::soas_div_req_type div_req,
   output soas_pkg::soas_div_rsp_type div_rsp
);
   import soas_pkg::*;

   logic [DIV_W-1:0]      quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [DIV_STEP_W-1:0] steps_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    rem_sh;
   logic                  ge;
   logic [DIVISOR_W-1:0]  rem_in;

   // One restoring step
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      ge     = (rem_sh >= {1'b0, divisor_ff});
      rem_in = ge ? DIVISOR_W'(rem_sh - {1'b0, divisor_ff}) : DIVISOR_W'(rem_sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !div_req.start && busy_ff && (steps_ff == DIV_STEP_W'(1));
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && steps_ff == DIV_STEP_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff     <= div_req.dividend;
         rem_ff     <= '0;
         divisor_ff <= div_req.divisor;
         steps_ff   <= div_req.steps;
      end else if (busy_ff) begin
         quo_ff   <= {quo_ff[DIV_W-2:0], ge};
         rem_ff   <= rem_in;
         steps_ff <= steps_ff - DIV_STEP_W'(1);
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ rtl/core/soas_front.sv @@
// Front end: takes samples, screens outliers and sums a round.
module soas_front #(
   parameter int  MAX_SENSORS = soas_pkg::MAX_SENSORS_DEFAULT,
   localparam int CNT_W = $clog2(MAX_SENSORS + 1),
   localparam int SUM_W = soas_pkg::TEMP_W + CNT_W,
   localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1,
   localparam int REC_W = SUM_W + CNT_W + MAX_SENSORS + soas_pkg::TIME_W
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [soas_pkg::TEMP_W-1:0] req_temperature,
   input  logic [soas_pkg::TIME_W-1:0]        req_time_ms,
   input  logic [soas_pkg::CSR_W-1:0]         sensor_count,
   input  logic                               back_quiet,
   input  soas_pkg::soas_hint_type            hint,
   output logic                               rec_push,
   output logic [REC_W-1:0]                   rec_data
);
   import soas_pkg::*;

   localparam int CMP_W = TEMP_W + 2;

   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [MAX_SENSORS-1:0]   rej_ff, rej_in;
   logic signed [TEMP_W-1:0] ref_ff, ref_in;

   logic                     accept;
   logic                     last;
   logic                     reject;
   logic [CSR_W-1:0]         n_eff;
   logic signed [CMP_W-1:0]  t_ext, t2, r_ext, r3;

   // A new round waits until the back end has settled the previous one
   assign req_full = (idx_ff == '0) && !back_quiet;
   assign accept   = req_push && !req_full;

   // Clamp the round length to 1..MAX_SENSORS
   always_comb begin
      priority if (sensor_count == '0) begin
         n_eff = CSR_W'(1);
      end else if (sensor_count > CSR_W'(MAX_SENSORS)) begin
         n_eff = CSR_W'(MAX_SENSORS);
      end else begin
         n_eff = sensor_count;
      end
   end

   // Outlier test against the round reference
   always_comb begin
      ref_in = (idx_ff == '0) ? (hint.primed ? hint.ref_avg : req_temperature) : ref_ff;
      t_ext  = CMP_W'(req_temperature);
      t2     = t_ext <<< 1;
      r_ext  = CMP_W'(ref_in);
      r3     = r_ext + (r_ext <<< 1);
      reject = (t2 < r_ext) || (t2 > r3);
      last   = (CSR_W'(idx_ff) + CSR_W'(1)) >= n_eff;
   end

   // Accumulate the round
   always_comb begin
      sum_in = sum_ff + (reject ? SUM_W'(0) : SUM_W'(req_temperature));
      cnt_in = cnt_ff + (reject ? CNT_W'(0) : CNT_W'(1));
      rej_in = rej_ff | (reject ? (MAX_SENSORS'(1) << idx_ff) : MAX_SENSORS'(0));
      idx_in = idx_ff + IDX_W'(1);
   end

   // Round record toward the back end
   assign rec_push = accept && last;
   assign rec_data = {sum_in, cnt_in, rej_in, req_time_ms};

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
         rej_ff <= '0;
      end else if (accept) begin
         if (last) begin
            idx_ff <= '0;
            sum_ff <= '0;
            cnt_ff <= '0;
            rej_ff <= '0;
         end else begin
            idx_ff <= idx_in;
            sum_ff <= sum_in;
            cnt_ff <= cnt_in;
            rej_ff <= rej_in;
         end
      end
   end

   // Reference is latched at the first sample of a round
   always_ff @(posedge clock) begin
      if (accept) begin
         ref_ff <= ref_in;
      end
   end

endmodule

@@ rtl/core/soas_back.sv @@
// Back end: round average, history update and slope.
module soas_back #(
   parameter int  MAX_SENSORS = soas_pkg::MAX_SENSORS_DEFAULT,
   localparam int CNT_W = $clog2(MAX_SENSORS + 1),
   localparam int SUM_W = soas_pkg::TEMP_W + CNT_W,
   localparam int REC_W = SUM_W + CNT_W + MAX_SENSORS + soas_pkg::TIME_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rec_empty,
   output logic                        rec_pop,
   input  logic [REC_W-1:0]            rec_data,
   input  logic                        res_full,
   output logic                        res_push,
   output soas_pkg::soas_result_type   res_data,
   output soas_pkg::soas_hint_type     hint,
   output logic                        idle,
   output soas_pkg::soas_div_req_type  div_req,
   input  soas_pkg::soas_div_rsp_type  div_rsp
);
   import soas_pkg::*;

   localparam int AVG_STEPS = SUM_W - 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_UPDATE,
      ST_MUL,
      ST_SLOPE,
      ST_SLOPE_WAIT,
      ST_PUSH
   } state_type;

   state_type                 state_ff;

   // History and result state
   logic                      primed_ff;
   logic signed [TEMP_W-1:0]  avg_hist_ff [3];
   logic [TIME_W-1:0]         time_hist_ff [3];
   logic signed [SLOPE_W-1:0] slope_ff;

   // Current round
   logic                      sum_neg_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [MAX_SENSORS-1:0]    mask_ff;
   logic [TIME_W-1:0]         time_ff;
   logic signed [TEMP_W-1:0]  r2_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [TIME_W-1:0]         dt_ff;

   // Divider command registers
   logic                      div_start_ff;
   logic [DIV_W-1:0]          div_dividend_ff;
   logic [DIVISOR_W-1:0]      div_divisor_ff;
   logic [DIV_STEP_W-1:0]     div_steps_ff;

   // Decoded record and helpers
   logic signed [SUM_W-1:0]   rec_sum;
   logic [CNT_W-1:0]          rec_cnt;
   logic [MAX_SENSORS-1:0]    rec_mask;
   logic [TIME_W-1:0]         rec_time;
   logic signed [SUM_W-1:0]   sum_abs;
   soas_status_type           status_cur;
   logic signed [TEMP_W-1:0]  avg_q;
   logic signed [TEMP_W-1:0]  r2_in;
   logic signed [DT_W-1:0]    dtemp;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_abs;
   logic [DIV_W-1:0]          slope_sat;
   logic signed [SLOPE_W-1:0] slope_mag;
   logic signed [SLOPE_W-1:0] slope_in;
   logic signed [SLOPE_W-1:0] slope_zero_dt;

   // Unpack the round record
   always_comb begin
      rec_time = rec_data[TIME_W-1:0];
      rec_mask = rec_data[TIME_W +: MAX_SENSORS];
      rec_cnt  = rec_data[TIME_W + MAX_SENSORS +: CNT_W];
      rec_sum  = rec_data[TIME_W + MAX_SENSORS + CNT_W +: SUM_W];
      sum_abs  = rec_sum[SUM_W-1] ? -rec_sum : rec_sum;
   end

   // Status of the current round
   always_comb begin
      priority if (cnt_ff == '0) begin
         status_cur = STATUS_ALL_REJECTED;
      end else if (mask_ff != '0) begin
         status_cur = STATUS_SOME_REJECTED;
      end else begin
         status_cur = STATUS_ALL_GOOD;
      end
   end

   // Signed average from the divider magnitude
   always_comb begin
      avg_q = TEMP_W'(div_rsp.quotient);
      r2_in = sum_neg_ff ? -avg_q : avg_q;
   end

   // Scaled difference and slope saturation
   always_comb begin
      dtemp         = DT_W'(avg_hist_ff[2]) - DT_W'(avg_hist_ff[0]);
      prod_in       = PROD_W'(dtemp) * PROD_W'(MS_PER_S);
      prod_abs      = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
      slope_sat     = (div_rsp.quotient > DIV_W'(SLOPE_LIMIT)) ?
                      DIV_W'(SLOPE_LIMIT) : div_rsp.quotient;
      slope_mag     = SLOPE_W'(slope_sat);
      slope_in      = prod_ff[PROD_W-1] ? -slope_mag : slope_mag;
      slope_zero_dt = (prod_ff == '0) ? SLOPE_W'(0) :
                      (prod_ff[PROD_W-1] ? -SLOPE_W'(SLOPE_LIMIT) : SLOPE_W'(SLOPE_LIMIT));
   end

   // Sequencer, history and registered divider command
   always_ff @(posedge clock) begin
      if (reset) begin
         div_start_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         slope_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            avg_hist_ff[i]  <= '0;
            time_hist_ff[i] <= '0;
         end
      end else begin
         // Divider start pulse: average of a round with accepted samples, or slope
         div_start_ff <= ((state_ff == ST_IDLE) && !rec_empty && (rec_cnt != '0)) ||
                         ((state_ff == ST_SLOPE) && (dt_ff != '0));
         unique case (state_ff)
            ST_IDLE: begin
               if (!rec_empty) begin
                  sum_neg_ff      <= rec_sum[SUM_W-1];
                  cnt_ff          <= rec_cnt;
                  mask_ff         <= rec_mask;
                  time_ff         <= rec_time;
                  r2_ff           <= '0;
                  div_dividend_ff <= DIV_W'(sum_abs[AVG_STEPS-1:0]) << (DIV_W - AVG_STEPS);
                  div_divisor_ff  <= DIVISOR_W'(rec_cnt);
                  div_steps_ff    <= DIV_STEP_W'(AVG_STEPS);
                  if (rec_cnt != '0) begin
                     state_ff <= ST_AVG;
                  end else begin
                     state_ff <= ST_UPDATE;
                  end
               end
            end
            ST_AVG: begin
               if (div_rsp.done) begin
                  r2_ff    <= r2_in;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (!primed_ff) begin
                  // Priming needs a clean round
                  if (status_cur == STATUS_ALL_GOOD) begin
                     for (int i = 0; i < 3; i++) begin
                        avg_hist_ff[i]  <= r2_ff;
                        time_hist_ff[i] <= time_ff;
                     end
                     slope_ff  <= '0;
                     primed_ff <= 1'b1;
                  end
                  state_ff <= ST_PUSH;
               end else if (status_cur != STATUS_ALL_REJECTED) begin
                  if (avg_hist_ff[1] != r2_ff) begin
                     avg_hist_ff[0]  <= avg_hist_ff[1];
                     time_hist_ff[0] <= time_hist_ff[1];
                     avg_hist_ff[1]  <= r2_ff;
                     time_hist_ff[1] <= time_ff;
                  end
                  avg_hist_ff[2]  <= r2_ff;
                  time_hist_ff[2] <= time_ff;
                  state_ff        <= ST_MUL;
               end else begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               dt_ff    <= time_hist_ff[2] - time_hist_ff[0];
               state_ff <= ST_SLOPE;
            end
            ST_SLOPE: begin
               if (dt_ff == '0) begin
                  slope_ff <= slope_zero_dt;
                  state_ff <= ST_PUSH;
               end else begin
                  div_dividend_ff <= DIV_W'(prod_abs);
                  div_divisor_ff  <= dt_ff;
                  div_steps_ff    <= DIV_STEP_W'(DIV_W);
                  state_ff        <= ST_SLOPE_WAIT;
               end
            end
            ST_SLOPE_WAIT: begin
               if (div_rsp.done) begin
                  slope_ff <= slope_in;
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (!res_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Handshakes and outputs
   assign rec_pop  = (state_ff == ST_IDLE) && !rec_empty;
   assign res_push = (state_ff == ST_PUSH) && !res_full;
   assign idle     = (state_ff == ST_IDLE);

   assign res_data.average_temp  = avg_hist_ff[2];
   assign res_data.temp_slope    = slope_ff;
   assign res_data.status        = status_cur;
   assign res_data.rejected_mask = MASK_W'(mask_ff);

   assign hint.primed  = primed_ff;
   assign hint.ref_avg = avg_hist_ff[1];

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = div_dividend_ff;
   assign div_req.divisor  = div_divisor_ff;
   assign div_req.steps    = div_steps_ff;

endmodule

@@ rtl/core/soas_checker.sv @@
// Port-level checks for the sensor outlier average and slope unit.
module soas_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_push,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic [soas_pkg::STATUS_W-1:0]       rsp_status,
   input logic [soas_pkg::MASK_W-1:0]         rsp_rejected_mask
);
   import soas_pkg::*;

   // Reset leaves both queues empty and the front end open
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");

   // A clean round reports no rejected sample
   a_good_mask: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == STATUS_ALL_GOOD) |-> (rsp_rejected_mask == '0))
      else $error("clean round with reject bits");

   // Any rejection status carries at least one reject bit
   a_bad_mask: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != STATUS_ALL_GOOD) |-> (rsp_rejected_mask != '0))
      else $error("rejection status without reject bits");

   // A waiting result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result vanished");

   logic unused_push;
   assign unused_push = req_push;

endmodule

bind sensor_outlier_average_and_slope_unit soas_checker u_checker (.*);
